// ----- src/tgfp_pkg.sv -----
// ----------------------------------------------------------------------------
// tgfp_pkg
// shared types and constants of the telemetry gps frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package tgfp_pkg;

  // frame header characters
  localparam logic [7:0] CharStart  = 8'h24;  // '$'
  localparam logic [7:0] CharSecond = 8'h54;  // 'T'
  localparam logic [7:0] CharGFrame = 8'h47;  // 'G'

  // payload bytes of a g frame, checksum byte follows
  localparam int unsigned PayloadLen = 14;
  localparam int unsigned CntW       = 4;
  localparam logic [CntW-1:0] PayloadLast = CntW'(PayloadLen);

  // status byte: satellites live above the fix type bits
  localparam int unsigned SatsShift = 2;
  localparam int unsigned SatsW     = 6;

  // divide by 100 through a reciprocal: q = (n * Magic) >> 37, exact for 32-bit n
  localparam logic [31:0] Div100Magic = 32'h51EB_851F;
  localparam int unsigned Div100Shift = 37;
  localparam int unsigned QuoW        = 25;   // floor(2^31 / 100) fits
  localparam int unsigned ResW        = 26;
  localparam logic [31:0] Hundred     = 32'd100;
  localparam logic [6:0]  HalfHundred = 7'd50;

  // configuration
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic [SatsW-1:0] MinSatsReset = 6'd5;

  typedef enum logic [0:0] {
    CFG_MIN_SATS = 1'b0
  } cfg_idx_e;

  // parser state, one-hot
  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_GOT_START  = 4'b0010,
    PH_GOT_SECOND = 4'b0100,
    PH_PAYLOAD    = 4'b1000
  } phase_e;

  // advance strobes of the two divider stages
  typedef struct packed {
    logic mul_en;
    logic fin_en;
  } pipe_en_t;

endpackage

`default_nettype wire

// ----- src/tgfp_div100.sv -----
// ----------------------------------------------------------------------------
// tgfp_div100
// two-stage signed divide by 100: reciprocal multiply, then remainder rounding
// ----------------------------------------------------------------------------
`default_nettype none

module tgfp_div100 (
  input  wire logic                          clk_i,
  input  wire logic [31:0]                   mag_i,
  input  wire logic                          neg_i,
  input  wire logic                          round_i,
  input  wire tgfp_pkg::pipe_en_t            en_i,
  output logic      [tgfp_pkg::ResW-1:0]     quo_o
);

  logic [63:0]                 prod;
  logic [tgfp_pkg::QuoW-1:0]   q_q;
  logic [31:0]                 mag_q;
  logic                        neg_q;
  logic [31:0]                 q100;
  logic [31:0]                 rem_full;
  logic                        round_up;
  logic [tgfp_pkg::ResW-1:0]   q_round;
  logic [tgfp_pkg::ResW-1:0]   quo_d;
  logic [tgfp_pkg::ResW-1:0]   quo_q;

  // truncated quotient of the magnitude
  assign prod = {32'b0, mag_i} * {32'b0, tgfp_pkg::Div100Magic};

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      q_q   <= prod[tgfp_pkg::Div100Shift +: tgfp_pkg::QuoW];
      mag_q <= mag_i;
      neg_q <= neg_i;
    end
  end

  // remainder, half-away rounding on the magnitude, then sign back
  always_comb begin
    q100     = 32'(q_q) * tgfp_pkg::Hundred;
    rem_full = mag_q - q100;
    round_up = round_i && (rem_full[6:0] >= tgfp_pkg::HalfHundred);
    q_round  = tgfp_pkg::ResW'(q_q) + tgfp_pkg::ResW'(round_up);
    quo_d    = neg_q ? (tgfp_pkg::ResW'(0) - q_round) : q_round;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fin_en) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ----- src/telemetry_gps_frame_parser.sv -----
// ----------------------------------------------------------------------------
// telemetry_gps_frame_parser
// light-telemetry g frame parser with fixed-point position decode
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while in_stall_o is low. The
// parser hunts for the header '$' 'T' 'G', shifts the 14 payload bytes
// into a byte shift line and checks the xor of payload and checksum. A
// good frame is handed to a three-stage result pipeline (capture,
// reciprocal multiply, rounding) whose rounding register drives the
// output. Latitude and longitude are divided by 100 rounded half away
// from zero, altitude divided by 100 truncated and kept to 16 bits. The
// sticky fix flag rises once a good frame reports at least min_sats_q
// satellites and only reset clears it. Frames with a bad checksum or an
// unknown type are dropped without a result. in_stall_o is high only
// while a finished frame sits in the capture stage and the two stages
// behind it are held by a stalled output, so under a free-running output
// side every cycle accepts a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_gps_frame_parser (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // byte input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [7:0]                           rx_byte_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [25:0]                        latitude_o,
  output logic signed [25:0]                        longitude_o,
  output logic signed [15:0]                        altitude_o,
  output logic        [5:0]                         satellites_o,
  output logic                                      fix_seen_o,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [tgfp_pkg::PaddrW-1:0]          paddr,
  input  wire logic [tgfp_pkg::PdataW-1:0]          pwdata,
  output logic      [tgfp_pkg::PdataW-1:0]          prdata,
  output logic                                      pready
);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [tgfp_pkg::SatsW-1:0] min_sats_q;
  tgfp_pkg::cfg_idx_e         cfg_idx;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = tgfp_pkg::cfg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sats_q <= tgfp_pkg::MinSatsReset;
    end else if (cfg_wr && (cfg_idx == tgfp_pkg::CFG_MIN_SATS)) begin
      min_sats_q <= pwdata[tgfp_pkg::SatsW-1:0];
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tgfp_pkg::CFG_MIN_SATS: prdata = tgfp_pkg::PdataW'(min_sats_q);
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline handshake
  // --------------------------------------------------------------------------
  logic               in_acc;
  logic               s1_valid_q;
  logic               s2_valid_q;
  logic               out_valid_q;
  logic               adv_fin;
  logic               adv_mul;
  logic               s1_load;
  tgfp_pkg::pipe_en_t pipe_en;

  // rounding stage moves when the output register is free or being drained
  assign adv_fin = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign adv_mul = s1_valid_q && (!s2_valid_q || adv_fin);
  // hold bytes only while a captured frame cannot move on
  assign in_stall_o = s1_valid_q && !adv_mul;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pipe_en.mul_en = adv_mul;
  assign pipe_en.fin_en = adv_fin;

  // --------------------------------------------------------------------------
  // header hunt and payload collection
  // --------------------------------------------------------------------------
  tgfp_pkg::phase_e           phase_q, phase_d;
  logic [tgfp_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]                 xor_q, xor_d;
  logic [7:0]                 xor_next;
  logic                       shift_en;
  logic [7:0]                 store_q [tgfp_pkg::PayloadLen];

  assign xor_next = xor_q ^ rx_byte_i;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    shift_en = 1'b0;
    s1_load  = 1'b0;
    if (in_acc) begin
      unique case (phase_q)
        tgfp_pkg::PH_IDLE: begin
          if (rx_byte_i == tgfp_pkg::CharStart) begin
            phase_d = tgfp_pkg::PH_GOT_START;
          end
        end
        // any other byte, a repeated '$' too, keeps waiting for 'T'
        tgfp_pkg::PH_GOT_START: begin
          if (rx_byte_i == tgfp_pkg::CharSecond) begin
            phase_d = tgfp_pkg::PH_GOT_SECOND;
          end
        end
        // frame type: only g frames are decoded
        tgfp_pkg::PH_GOT_SECOND: begin
          if (rx_byte_i == tgfp_pkg::CharGFrame) begin
            phase_d = tgfp_pkg::PH_PAYLOAD;
            cnt_d   = '0;
            xor_d   = '0;
          end else begin
            phase_d = tgfp_pkg::PH_IDLE;
          end
        end
        tgfp_pkg::PH_PAYLOAD: begin
          xor_d = xor_next;
          if (cnt_q != tgfp_pkg::PayloadLast) begin
            shift_en = 1'b1;
            cnt_d    = cnt_q + 1'b1;
          end else begin
            // checksum byte closes the frame
            phase_d = tgfp_pkg::PH_IDLE;
            cnt_d   = '0;
            s1_load = (xor_next == 8'h00);
          end
        end
        default: begin
          phase_d = tgfp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tgfp_pkg::PH_IDLE;
      cnt_q   <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

  // byte shift line: after 14 shifts byte k sits at place k
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < tgfp_pkg::PayloadLen - 1; i++) begin
        store_q[i] <= store_q[i+1];
      end
      store_q[tgfp_pkg::PayloadLen-1] <= rx_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // capture stage: little-endian fields, magnitudes and sticky fix flag
  // --------------------------------------------------------------------------
  logic [31:0]                lat_raw, lon_raw, alt_raw;
  logic [tgfp_pkg::SatsW-1:0] sats;
  logic                       fix_flag_q, fix_flag_d;

  assign lat_raw = {store_q[3],  store_q[2],  store_q[1], store_q[0]};
  assign lon_raw = {store_q[7],  store_q[6],  store_q[5], store_q[4]};
  assign alt_raw = {store_q[12], store_q[11], store_q[10], store_q[9]};
  assign sats    = store_q[13][7:tgfp_pkg::SatsShift];

  assign fix_flag_d = fix_flag_q || (s1_load && (sats >= min_sats_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_flag_q <= 1'b0;
    end else begin
      fix_flag_q <= fix_flag_d;
    end
  end

  logic [31:0]                s1_lat_mag_q, s1_lon_mag_q, s1_alt_mag_q;
  logic                       s1_lat_neg_q, s1_lon_neg_q, s1_alt_neg_q;
  logic [tgfp_pkg::SatsW-1:0] s1_sats_q, s2_sats_q, out_sats_q;
  logic                       s1_fix_q, s2_fix_q, out_fix_q;

  // magnitude of the most negative value is 2^31, still exact unsigned
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_lat_neg_q <= lat_raw[31];
      s1_lon_neg_q <= lon_raw[31];
      s1_alt_neg_q <= alt_raw[31];
      s1_lat_mag_q <= lat_raw[31] ? (32'd0 - lat_raw) : lat_raw;
      s1_lon_mag_q <= lon_raw[31] ? (32'd0 - lon_raw) : lon_raw;
      s1_alt_mag_q <= alt_raw[31] ? (32'd0 - alt_raw) : alt_raw;
      s1_sats_q    <= sats;
      s1_fix_q     <= fix_flag_d;
    end
  end

  // side fields ride along with the divider stages
  always_ff @(posedge clk_i) begin
    if (adv_mul) begin
      s2_sats_q <= s1_sats_q;
      s2_fix_q  <= s1_fix_q;
    end
    if (adv_fin) begin
      out_sats_q <= s2_sats_q;
      out_fix_q  <= s2_fix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_load || (s1_valid_q && !adv_mul);
      s2_valid_q  <= adv_mul || (s2_valid_q && !adv_fin);
      out_valid_q <= adv_fin || (out_valid_q && out_stall_i);
    end
  end

  // --------------------------------------------------------------------------
  // divide by 100 units
  // --------------------------------------------------------------------------
  logic [tgfp_pkg::ResW-1:0] lat_quo, lon_quo, alt_quo;

  tgfp_div100 u_div_lat (
    .clk_i   (clk_i),
    .mag_i   (s1_lat_mag_q),
    .neg_i   (s1_lat_neg_q),
    .round_i (1'b1),
    .en_i    (pipe_en),
    .quo_o   (lat_quo)
  );

  tgfp_div100 u_div_lon (
    .clk_i   (clk_i),
    .mag_i   (s1_lon_mag_q),
    .neg_i   (s1_lon_neg_q),
    .round_i (1'b1),
    .en_i    (pipe_en),
    .quo_o   (lon_quo)
  );

  // altitude truncates toward zero
  tgfp_div100 u_div_alt (
    .clk_i   (clk_i),
    .mag_i   (s1_alt_mag_q),
    .neg_i   (s1_alt_neg_q),
    .round_i (1'b0),
    .en_i    (pipe_en),
    .quo_o   (alt_quo)
  );

  assign out_valid_o  = out_valid_q;
  assign latitude_o   = lat_quo;
  assign longitude_o  = lon_quo;
  assign altitude_o   = alt_quo[15:0];
  assign satellites_o = out_sats_q;
  assign fix_seen_o   = out_fix_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a finished frame never overwrites a capture that is still held
  a_no_capture_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |-> (!s1_valid_q || adv_mul))
    else $error("frame captured over a held capture stage");

  // input only stalls behind an occupied capture stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty capture stage");

  // sticky fix flag never clears outside reset
  a_fix_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fix_flag_q |=> fix_flag_q)
    else $error("fix flag dropped");

  // a reported fix implies the sticky flag is set
  a_fix_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fix_seen_o) |-> fix_flag_q)
    else $error("fix reported without sticky flag");

  // payload counter stays within the frame
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tgfp_pkg::PayloadLast)
    else $error("payload counter out of range");

endmodule

`default_nettype wire
